// File: design/eds_pkg.sv
// Package for the elevator direction scheduler.
// Holds the command and direction codes, the one-hot direction state and the item types.
// No dependencies.
package eds_pkg;

    localparam int FLOOR_W = 3;
    localparam int CALL_W  = 8;
    localparam int CMD_W   = 3;
    localparam int DIR_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_UP    = 3'd1,
        CMD_DOWN  = 3'd2,
        CMD_OPEN  = 3'd3,
        CMD_CLOSE = 3'd4
    } cmd_t;

    // Direction codes as they appear on the result port
    typedef enum logic [DIR_W-1:0] {
        DIR_UP   = 2'd0,
        DIR_DOWN = 2'd1,
        DIR_IDLE = 2'd2
    } dir_code_t;

    // Travel direction state, one-hot
    typedef enum logic [2:0] {
        ST_UP   = 3'b001,
        ST_DOWN = 3'b010,
        ST_IDLE = 3'b100
    } dir_state_t;

    typedef struct packed {
        logic [FLOOR_W-1:0] floor_index;
        logic [CALL_W-1:0]  up_calls;
        logic [CALL_W-1:0]  down_calls;
        logic [CALL_W-1:0]  car_calls;
    } item_t;

    typedef struct packed {
        cmd_t       command;
        dir_state_t dir;
        logic       door_open;
    } decision_t;

    function automatic dir_code_t dir_code(input dir_state_t st);
        dir_code_t code;
        case (st)
            ST_UP:   code = DIR_UP;
            ST_DOWN: code = DIR_DOWN;
            default: code = DIR_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: design/eds_in_stage.sv
// Input register stage of the elevator direction scheduler.
// Captures one transaction and holds it until the decision stage takes it.
// Depends on eds_pkg.
module eds_in_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [eds_pkg::FLOOR_W-1:0] floor_index,
    input  logic [eds_pkg::CALL_W-1:0]  up_calls,
    input  logic [eds_pkg::CALL_W-1:0]  down_calls,
    input  logic [eds_pkg::CALL_W-1:0]  car_calls,
    input  logic                      advance,
    output logic                      item_valid,
    output eds_pkg::item_t            item
);

    logic           valid_reg;
    logic           valid_next;
    logic           load;
    eds_pkg::item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.floor_index <= floor_index;
            item_reg.up_calls    <= up_calls;
            item_reg.down_calls  <= down_calls;
            item_reg.car_calls   <= car_calls;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: design/eds_decide.sv
// Next-command decision of the elevator direction scheduler.
// Combinational: item plus current door and direction state in, command and next state out.
// Depends on eds_pkg.
module eds_decide #(
    parameter int NUM_FLOORS = 8
) (
    input  eds_pkg::item_t     item,
    input  eds_pkg::dir_state_t dir,
    input  logic               door_open,
    output eds_pkg::decision_t dec
);

    logic [eds_pkg::CALL_W-1:0]  all_mask;
    logic [eds_pkg::FLOOR_W-1:0] floor_c;
    logic [eds_pkg::CALL_W-1:0]  up_m;
    logic [eds_pkg::CALL_W-1:0]  dn_m;
    logic [eds_pkg::CALL_W-1:0]  car_m;
    logic [eds_pkg::CALL_W-1:0]  here;
    logic [eds_pkg::CALL_W-1:0]  below;
    logic [eds_pkg::CALL_W-1:0]  above;
    logic [eds_pkg::CALL_W-1:0]  any_m;
    logic                        calls_above;
    logic                        calls_below;

    always_comb
    begin
        for (int i = 0; i < eds_pkg::CALL_W; i++)
        begin
            all_mask[i] = (i < NUM_FLOORS);
        end
    end

    // floors past the top are taken as the top floor
    always_comb
    begin
        if (int'(item.floor_index) >= NUM_FLOORS)
        begin
            floor_c = eds_pkg::FLOOR_W'(NUM_FLOORS - 1);
        end
        else
        begin
            floor_c = item.floor_index;
        end
    end

    assign up_m        = item.up_calls & all_mask;
    assign dn_m        = item.down_calls & all_mask;
    assign car_m       = item.car_calls & all_mask;
    assign here        = eds_pkg::CALL_W'(1) << floor_c;
    assign below       = here - eds_pkg::CALL_W'(1);
    assign above       = all_mask & ~(below | here);
    assign any_m       = up_m | dn_m | car_m;
    assign calls_above = |(any_m & above);
    assign calls_below = |(any_m & below);

    always_comb
    begin
        dec.command   = eds_pkg::CMD_NONE;
        dec.dir       = dir;
        dec.door_open = door_open;
        if (door_open)
        begin
            dec.command   = eds_pkg::CMD_CLOSE;
            dec.door_open = 1'b0;
        end
        else if (|(car_m & here))
        begin
            dec.command   = eds_pkg::CMD_OPEN;
            dec.door_open = 1'b1;
        end
        else
        begin
            case (dir)
                eds_pkg::ST_UP:
                begin
                    if (|(up_m & here))
                    begin
                        dec.command   = eds_pkg::CMD_OPEN;
                        dec.door_open = 1'b1;
                    end
                    else if (calls_above)
                    begin
                        dec.command = eds_pkg::CMD_UP;
                    end
                    else if (calls_below)
                    begin
                        dec.command = eds_pkg::CMD_DOWN;
                        dec.dir     = eds_pkg::ST_DOWN;
                    end
                    else
                    begin
                        dec.dir = eds_pkg::ST_IDLE;
                    end
                end
                eds_pkg::ST_DOWN:
                begin
                    if (|(dn_m & here))
                    begin
                        dec.command   = eds_pkg::CMD_OPEN;
                        dec.door_open = 1'b1;
                    end
                    else if (calls_below)
                    begin
                        dec.command = eds_pkg::CMD_DOWN;
                    end
                    else if (calls_above)
                    begin
                        dec.command = eds_pkg::CMD_UP;
                        dec.dir     = eds_pkg::ST_UP;
                    end
                    else
                    begin
                        dec.dir = eds_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    // idle car prefers to start upward
                    if (calls_above)
                    begin
                        dec.command = eds_pkg::CMD_UP;
                        dec.dir     = eds_pkg::ST_UP;
                    end
                    else if (calls_below)
                    begin
                        dec.command = eds_pkg::CMD_DOWN;
                        dec.dir     = eds_pkg::ST_DOWN;
                    end
                    else
                    begin
                        dec.dir = eds_pkg::ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// File: design/elevator_direction_scheduler.sv
// Elevator direction scheduler, top level.
// Input register, decision logic with door and direction state, result register.
// Depends on eds_pkg, eds_in_stage, eds_decide.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction per completed car
//   action, carrying floor_index and the up, down and car call masks.
//   Result channel (out_valid / out_stall): exactly one transaction per input,
//   carrying command (none, up, down, open, close) and travel_dir after the step.
//   Path: the accepting edge loads the input register; the result register
//   then loads from the decision logic once it is empty or out_stall is low.
//   Throughput: one transaction per cycle unless out_stall holds a result; the
//   door and direction state are updated in the same cycle the result register
//   loads, so back-to-back items see each other's state in order.
//   Reset: asynchronous, active low; the car is idle with the door closed and
//   both pipeline stages are empty.
//   Stall: when out_stall holds a full result register, the input register
//   keeps its item and in_stall rises once that register is also full; nothing
//   is dropped and the held result does not change.
module elevator_direction_scheduler #(
    parameter int NUM_FLOORS = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [eds_pkg::FLOOR_W-1:0] floor_index,
    input  logic [eds_pkg::CALL_W-1:0]  up_calls,
    input  logic [eds_pkg::CALL_W-1:0]  down_calls,
    input  logic [eds_pkg::CALL_W-1:0]  car_calls,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [eds_pkg::CMD_W-1:0]   command,
    output logic [eds_pkg::DIR_W-1:0]   travel_dir
);

    logic                out_ready;
    logic                fire;
    logic                item_valid;
    eds_pkg::item_t      item;
    eds_pkg::decision_t  dec;

    eds_pkg::dir_state_t dir_reg;
    logic                door_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    eds_pkg::cmd_t       command_reg;
    eds_pkg::dir_code_t  travel_dir_reg;

    assign out_ready      = !out_valid_reg || !out_stall;
    assign fire           = item_valid && out_ready;
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    eds_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .floor_index (floor_index),
        .up_calls    (up_calls),
        .down_calls  (down_calls),
        .car_calls   (car_calls),
        .advance     (out_ready),
        .item_valid  (item_valid),
        .item        (item)
    );

    eds_decide #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_decide (
        .item      (item),
        .dir       (dir_reg),
        .door_open (door_reg),
        .dec       (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= eds_pkg::ST_IDLE;
            door_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                dir_reg  <= dec.dir;
                door_reg <= dec.door_open;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            command_reg    <= dec.command;
            travel_dir_reg <= eds_pkg::dir_code(dec.dir);
        end
    end

    assign out_valid  = out_valid_reg;
    assign command    = command_reg;
    assign travel_dir = travel_dir_reg;

endmodule

// File: design/eds_checker.sv
// Port-level checker for the elevator direction scheduler, bound to the top level.
// Depends on eds_pkg and elevator_direction_scheduler.
module eds_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [eds_pkg::CMD_W-1:0]   command,
    input logic [eds_pkg::DIR_W-1:0]   travel_dir
);

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(command) && $stable(travel_dir))
        else $error("result changed while stalled");

    a_up_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == eds_pkg::CMD_UP |-> travel_dir == eds_pkg::DIR_UP)
        else $error("move up without up direction");

    a_down_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == eds_pkg::CMD_DOWN |-> travel_dir == eds_pkg::DIR_DOWN)
        else $error("move down without down direction");

    a_none_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && command == eds_pkg::CMD_NONE |-> travel_dir == eds_pkg::DIR_IDLE)
        else $error("no command while not idle");

endmodule

bind elevator_direction_scheduler eds_checker u_eds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .command    (command),
    .travel_dir (travel_dir)
);

// File: test/elevator_direction_scheduler_tb.sv
// Testbench for elevator_direction_scheduler: directed and random car actions
// checked against an in-bench model of the door and direction logic.
// Depends on eds_pkg and the elevator_direction_scheduler RTL.
module elevator_direction_scheduler_tb;

    localparam int FLOORS        = 8;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_HOLD = 60;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct {
        eds_pkg::cmd_t      cmd;
        eds_pkg::dir_code_t dir;
    } decision_rec_t;

    // Tracks car state, predicts one command per transaction, checks results
    class dispatch_tracker;
        eds_pkg::dir_code_t cur_dir;
        bit                 door_is_open;
        eds_pkg::cmd_t      last_cmd;
        decision_rec_t      pending_cmds[$];
        int                 errors;

        function new();
            cur_dir      = eds_pkg::DIR_IDLE;
            door_is_open = 1'b0;
            last_cmd     = eds_pkg::CMD_NONE;
            errors       = 0;
        endfunction

        function void note_call_item(logic [eds_pkg::FLOOR_W-1:0] fl_in,
                                     logic [eds_pkg::CALL_W-1:0] up_in,
                                     logic [eds_pkg::CALL_W-1:0] dn_in,
                                     logic [eds_pkg::CALL_W-1:0] car_in);
            logic [eds_pkg::CALL_W-1:0] mask, here, below, above, up, dn, car, any_call;
            int unsigned                fl;
            bit                         go_up, go_down;
            eds_pkg::cmd_t              c;
            decision_rec_t              rec;
            mask = eds_pkg::CALL_W'((1 << FLOORS) - 1);
            fl   = fl_in;
            if (fl >= FLOORS)
                fl = FLOORS - 1;
            up       = up_in & mask;
            dn       = dn_in & mask;
            car      = car_in & mask;
            here     = eds_pkg::CALL_W'(1) << fl;
            below    = here - 1'b1;
            above    = mask & ~(below | here);
            any_call = up | dn | car;
            go_up    = |(any_call & above);
            go_down  = |(any_call & below);
            c        = eds_pkg::CMD_NONE;
            if (door_is_open)
            begin
                c            = eds_pkg::CMD_CLOSE;
                door_is_open = 1'b0;
            end
            else if (|(car & here))
            begin
                c            = eds_pkg::CMD_OPEN;
                door_is_open = 1'b1;
            end
            else if (cur_dir == eds_pkg::DIR_UP)
            begin
                if (|(up & here))
                begin
                    c            = eds_pkg::CMD_OPEN;
                    door_is_open = 1'b1;
                end
                else if (go_up)
                    c = eds_pkg::CMD_UP;
                else if (go_down)
                begin
                    c       = eds_pkg::CMD_DOWN;
                    cur_dir = eds_pkg::DIR_DOWN;
                end
                else
                    cur_dir = eds_pkg::DIR_IDLE;
            end
            else if (cur_dir == eds_pkg::DIR_DOWN)
            begin
                if (|(dn & here))
                begin
                    c            = eds_pkg::CMD_OPEN;
                    door_is_open = 1'b1;
                end
                else if (go_down)
                    c = eds_pkg::CMD_DOWN;
                else if (go_up)
                begin
                    c       = eds_pkg::CMD_UP;
                    cur_dir = eds_pkg::DIR_UP;
                end
                else
                    cur_dir = eds_pkg::DIR_IDLE;
            end
            else
            begin
                // idle car: hall calls at this floor alone do not start it
                if (go_up)
                begin
                    c       = eds_pkg::CMD_UP;
                    cur_dir = eds_pkg::DIR_UP;
                end
                else if (go_down)
                begin
                    c       = eds_pkg::CMD_DOWN;
                    cur_dir = eds_pkg::DIR_DOWN;
                end
                else
                    cur_dir = eds_pkg::DIR_IDLE;
            end
            last_cmd = c;
            rec.cmd  = c;
            rec.dir  = cur_dir;
            pending_cmds.push_back(rec);
        endfunction

        function void check_result(logic [eds_pkg::CMD_W-1:0] cmd_port,
                                   logic [eds_pkg::DIR_W-1:0] dir_port);
            decision_rec_t want;
            if (pending_cmds.size() == 0)
            begin
                $error("unexpected result: command %0d travel_dir %0d", cmd_port, dir_port);
                errors++;
                return;
            end
            want = pending_cmds.pop_front();
            if (cmd_port !== want.cmd)
            begin
                $error("command: expected %0d, got %0d", want.cmd, cmd_port);
                errors++;
            end
            if (dir_port !== want.dir)
            begin
                $error("travel_dir: expected %0d, got %0d", want.dir, dir_port);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [eds_pkg::FLOOR_W-1:0] floor_index;
    logic [eds_pkg::CALL_W-1:0]  up_calls;
    logic [eds_pkg::CALL_W-1:0]  down_calls;
    logic [eds_pkg::CALL_W-1:0]  car_calls;
    logic                        out_valid;
    logic                        out_stall;
    logic [eds_pkg::CMD_W-1:0]   command;
    logic [eds_pkg::DIR_W-1:0]   travel_dir;

    dispatch_tracker tracker = new();
    bit              no_idle;
    int              cycle_count;

    // simulated car for the well-formed part of the random run
    logic [eds_pkg::FLOOR_W-1:0] car_floor;
    logic [eds_pkg::CALL_W-1:0]  car_up, car_dn, car_in;

    elevator_direction_scheduler #(
        .NUM_FLOORS(FLOORS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .floor_index(floor_index),
        .up_calls   (up_calls),
        .down_calls (down_calls),
        .car_calls  (car_calls),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .travel_dir (travel_dir)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [eds_pkg::CALL_W-1:0] rand_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return eds_pkg::CALL_W'(1) << $urandom_range(0, eds_pkg::CALL_W - 1);
            2:       return eds_pkg::CALL_W'($urandom);
            default: return '1;
        endcase
    endfunction

    // Offer one transaction after a random gap; valid stays high across gap-free items
    task automatic send_call(input logic [eds_pkg::FLOOR_W-1:0] fl,
                             input logic [eds_pkg::CALL_W-1:0] up,
                             input logic [eds_pkg::CALL_W-1:0] dn,
                             input logic [eds_pkg::CALL_W-1:0] car);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        floor_index <= fl;
        up_calls    <= up;
        down_calls  <= dn;
        car_calls   <= car;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_call_item(fl, up, dn, car);
    endtask

    // Move the simulated car by the last predicted command and post new calls
    task automatic advance_car();
        int pick;
        case (tracker.last_cmd)
            eds_pkg::CMD_UP:
                if (car_floor != eds_pkg::FLOOR_W'(FLOORS - 1))
                    car_floor++;
            eds_pkg::CMD_DOWN:
                if (car_floor != '0)
                    car_floor--;
            eds_pkg::CMD_OPEN:
            begin
                car_in[car_floor] = 1'b0;
                if (tracker.cur_dir == eds_pkg::DIR_DOWN)
                    car_dn[car_floor] = 1'b0;
                else
                    car_up[car_floor] = 1'b0;
            end
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            pick = $urandom_range(0, eds_pkg::CALL_W - 1);
            case ($urandom_range(0, 2))
                0:       car_up[pick] = 1'b1;
                1:       car_dn[pick] = 1'b1;
                default: car_in[pick] = 1'b1;
            endcase
        end
    endtask

    initial
    begin : stimulus
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        floor_index = '0;
        up_calls    = '0;
        down_calls  = '0;
        car_calls   = '0;
        no_idle     = 1'b0;
        car_floor   = '0;
        car_up      = '0;
        car_dn      = '0;
        car_in      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: idle handling, door open/close, travel, reversal, extremes
        send_call(3'd0, 8'h00, 8'h00, 8'h00);   // idle, no calls
        send_call(3'd3, 8'h08, 8'h08, 8'h00);   // idle, hall calls here only
        send_call(3'd3, 8'h00, 8'h00, 8'h08);   // car call here opens
        send_call(3'd3, 8'hFF, 8'hFF, 8'hFF);   // open door closes first
        send_call(3'd0, 8'h80, 8'h00, 8'h00);   // idle starts up
        send_call(3'd4, 8'h10, 8'h00, 8'h00);   // up call here while going up
        send_call(3'd4, 8'h00, 8'h00, 8'h00);
        send_call(3'd5, 8'h00, 8'h20, 8'h00);   // moving, nothing ahead or behind
        send_call(3'd2, 8'h00, 8'h00, 8'h80);
        send_call(3'd7, 8'h01, 8'h00, 8'h00);   // top floor, reverse down
        send_call(3'd5, 8'h00, 8'h20, 8'h00);   // down call here while going down
        send_call(3'd5, 8'hFF, 8'hFF, 8'hFF);
        send_call(3'd4, 8'h10, 8'h00, 8'h02);   // keep going down
        send_call(3'd0, 8'h40, 8'h00, 8'h00);   // bottom floor, reverse up
        send_call(3'd6, 8'h00, 8'h00, 8'h00);   // up with no calls goes idle
        send_call(3'd7, 8'h00, 8'h01, 8'h00);   // idle starts down
        send_call(3'd3, 8'h00, 8'h00, 8'h00);   // down with no calls goes idle
        send_call(3'd7, 8'hFF, 8'hFF, 8'hFF);
        send_call(3'd0, 8'h00, 8'h00, 8'h00);
        send_call(3'd0, 8'hFF, 8'hFF, 8'hFE);
        send_call(3'd7, 8'h80, 8'h7F, 8'h00);
        send_call(3'd7, 8'h00, 8'h00, 8'h00);
        send_call(3'd7, 8'h00, 8'h80, 8'h00);   // down call here while going up

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 4) == 0)
                send_call(eds_pkg::FLOOR_W'($urandom), rand_mask(), rand_mask(),
                          rand_mask());
            else
            begin
                advance_car();
                send_call(car_floor, car_up, car_dn, car_in);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (tracker.pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_cmds.size() == 0)
            $display("[elevator_direction_scheduler] OK");
        else
            $display("[elevator_direction_scheduler] ERROR");
        $finish;
    end

    initial
    begin : result_side
        int hold;
        int n_results;
        hold      = 0;
        n_results = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                tracker.check_result(command, travel_dir);
                n_results++;
                // one long hold-off lets the pipeline fill and back up the input
                if (n_results == PRESSURE_AT)
                    hold = PRESSURE_HOLD;
                else
                    hold = no_idle ? 0 : $urandom_range(0, 10);
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[elevator_direction_scheduler] ERROR");
        $finish;
    end

endmodule
